>>> design/pbrd_pkg.sv
// ----------------------------------------------------------------------------
// PackBits decoder package
// Shared widths, header code and the command/status structs that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
package pbrd_pkg;

    localparam int unsigned ByteW      = 8;
    localparam int unsigned CountW     = 3;
    localparam int unsigned RemW       = 8;
    localparam int unsigned LaneFields = 4;
    localparam int unsigned MaxResults = 32;

    // Header code that announces nothing
    localparam logic [ByteW-1:0] HdrNoop = 8'd128;

    typedef logic [ByteW-1:0] t_byte;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_hdr;  // header word accepted
        logic load_lit;  // literal word accepted, emit it
        logic load_rep;  // repeat word accepted, latch it
        logic emit;      // emit one result of the repeat run
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_free;  // output register can take a result this cycle
        logic hdr_lit;   // input word is a literal-run header
        logic hdr_rep;   // input word is a repeat-run header
        logic rem_one;   // one byte left in the run
        logic run_end;   // next repeat result closes the run
    } t_status;

endpackage

>>> design/pbrd_ifs.sv
// ----------------------------------------------------------------------------
// PackBits decoder channels
// Valid/ready channels for compressed input words and decoded result words.
// ----------------------------------------------------------------------------
interface pbrd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_in;

    modport source (output valid, output data_byte, output last_in, input ready);
    modport sink   (input valid, input data_byte, input last_in, output ready);
endinterface

interface pbrd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] lane0_byte;
    logic [7:0] lane1_byte;
    logic [7:0] lane2_byte;
    logic [7:0] lane3_byte;
    logic [2:0] lane_count;
    logic       last_of_run;

    modport source (output valid, output lane0_byte, output lane1_byte,
                    output lane2_byte, output lane3_byte, output lane_count,
                    output last_of_run, input ready);
    modport sink   (input valid, input lane0_byte, input lane1_byte,
                    input lane2_byte, input lane3_byte, input lane_count,
                    input last_of_run, output ready);
endinterface

>>> design/pbrd_ctrl.sv
// ----------------------------------------------------------------------------
// PackBits decoder controller
// Tracks the decode phase, gates input ready and issues datapath commands.
// ----------------------------------------------------------------------------
module pbrd_ctrl
    import pbrd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_last_in,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_HEADER,
        S_LITERAL,
        S_REPEAT,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    // Ready per phase: literals need room in the output register
    always_comb begin
        case (r_state)
            S_HEADER:  o_in_ready = 1'b1;
            S_LITERAL: o_in_ready = i_status.out_free;
            S_REPEAT:  o_in_ready = 1'b1;
            S_EMIT:    o_in_ready = 1'b0;
            default:   o_in_ready = 1'b0;
        endcase
    end

    assign accept = i_in_valid && o_in_ready;

    // Commands
    always_comb begin
        o_cmd          = '0;
        o_cmd.load_hdr = accept && (r_state == S_HEADER);
        o_cmd.load_lit = accept && (r_state == S_LITERAL);
        o_cmd.load_rep = accept && (r_state == S_REPEAT);
        o_cmd.emit     = (r_state == S_EMIT) && i_status.out_free;
    end

    // Next phase
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_HEADER: begin
                if (accept) begin
                    if (i_last_in)             n_state = S_HEADER;
                    else if (i_status.hdr_lit) n_state = S_LITERAL;
                    else if (i_status.hdr_rep) n_state = S_REPEAT;
                    else                       n_state = S_HEADER;
                end
            end
            S_LITERAL: begin
                if (accept && (i_last_in || i_status.rem_one)) n_state = S_HEADER;
            end
            S_REPEAT: begin
                if (accept) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (o_cmd.emit && i_status.run_end) n_state = S_HEADER;
            end
            default: n_state = S_HEADER;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HEADER;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef ASSERT_OFF
    // Input is never taken while a run is being emitted
    a_no_accept_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> !accept)
        else $error("input accepted during repeat emission");

    // A repeat word always leads into emission
    a_rep_to_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_rep |=> (r_state == S_EMIT))
        else $error("repeat word did not start emission");

    // Emission only with room in the output register
    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit || o_cmd.load_lit) |-> i_status.out_free)
        else $error("result issued without output room");
`endif

endmodule

>>> design/pbrd_dp.sv
// ----------------------------------------------------------------------------
// PackBits decoder datapath
// Holds the run count, the repeat byte and the result output register.
// ----------------------------------------------------------------------------
module pbrd_dp
    import pbrd_pkg::*;
#(
    parameter int OUT_LANES = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  t_byte             i_data_byte,
    input  logic              i_last_in,
    input  logic              i_out_ready,
    output t_status           o_status,
    output logic              o_out_valid,
    output t_byte             o_lane [LaneFields],
    output logic [CountW-1:0] o_lane_count,
    output logic              o_last_of_run
);

    // Lanes per repeat result, clamped to the lane fields
    localparam int LaneBase = (OUT_LANES < 1) ? 1 :
                              (OUT_LANES > int'(LaneFields)) ? int'(LaneFields) : OUT_LANES;

    logic [RemW-1:0]   r_remaining;
    logic [RemW-1:0]   n_remaining;
    t_byte             r_byte;
    logic [CountW-1:0] r_lanes;
    logic [CountW-1:0] n_lanes;
    logic              r_out_valid;
    t_byte             r_lane [LaneFields];
    t_byte             n_lane [LaneFields];
    logic [CountW-1:0] r_count;
    logic [CountW-1:0] n_count;
    logic              r_last;

    logic [RemW:0]     rep_len;
    logic [RemW:0]     need_sum;
    logic [CountW-1:0] need;
    logic [CountW-1:0] chunk;
    logic              out_free;
    logic              run_end;

    assign out_free = !r_out_valid || i_out_ready;
    assign run_end  = r_remaining <= {{(RemW-CountW){1'b0}}, r_lanes};
    assign chunk    = run_end ? r_remaining[CountW-1:0] : r_lanes;

    // Repeat length 257 minus header
    assign rep_len  = 9'd257 - {1'b0, i_data_byte};

    // Lanes needed to keep the run within the result limit
    assign need_sum = {1'b0, r_remaining} + (RemW+1)'(MaxResults - 1);
    assign need     = CountW'(need_sum >> $clog2(MaxResults));
    assign n_lanes  = (need > CountW'(LaneBase)) ? need : CountW'(LaneBase);

    always_comb begin
        o_status          = '0;
        o_status.out_free = out_free;
        o_status.hdr_lit  = i_data_byte < HdrNoop;
        o_status.hdr_rep  = i_data_byte > HdrNoop;
        o_status.rem_one  = r_remaining == RemW'(1);
        o_status.run_end  = run_end;
    end

    // Next run count
    always_comb begin
        n_remaining = r_remaining;
        if (i_cmd.load_hdr) begin
            if (i_last_in)             n_remaining = '0;
            else if (o_status.hdr_lit) n_remaining = i_data_byte + RemW'(1);
            else if (o_status.hdr_rep) n_remaining = rep_len[RemW-1:0];
            else                       n_remaining = '0;
        end else if (i_cmd.load_lit) begin
            n_remaining = i_last_in ? '0 : r_remaining - RemW'(1);
        end else if (i_cmd.emit) begin
            n_remaining = r_remaining - {{(RemW-CountW){1'b0}}, chunk};
        end
    end

    // Result lanes: fill up to the count, zero the rest
    always_comb begin
        n_count = i_cmd.load_lit ? CountW'(1) : chunk;
        for (int k = 0; k < int'(LaneFields); k++) begin
            if (i_cmd.load_lit) begin
                n_lane[k] = (k == 0) ? i_data_byte : '0;
            end else begin
                n_lane[k] = (CountW'(k) < chunk) ? r_byte : '0;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remaining <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_remaining <= n_remaining;
            if (i_cmd.load_lit || i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_rep) begin
            r_byte  <= i_data_byte;
            r_lanes <= n_lanes;
        end
        if (i_cmd.load_lit || i_cmd.emit) begin
            r_lane  <= n_lane;
            r_count <= n_count;
            r_last  <= i_cmd.load_lit || run_end;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_lane        = r_lane;
    assign o_lane_count  = r_count;
    assign o_last_of_run = r_last;

`ifndef ASSERT_OFF
    // Every issued result carries one to four bytes
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_count != '0) && (r_count <= CountW'(LaneFields)))
        else $error("result lane count out of range");

    // A literal result is a single flagged byte
    a_lit_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_lit |=> (r_count == CountW'(1)) && r_last)
        else $error("literal result malformed");

    // Non-final repeat results are full
    a_full_chunk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit && !run_end |=> (r_count == r_lanes) && !r_last)
        else $error("partial repeat result before run end");
`endif

endmodule

>>> design/packbits_rle_decoder.sv
// ----------------------------------------------------------------------------
// PackBits run-length decoder
// Decodes a PackBits byte stream into results of up to four decoded bytes.
// ----------------------------------------------------------------------------
// Header and literal words are taken one per cycle while the output side
// keeps up; each literal word gives one single-byte result the next cycle.
// A repeat run costs its header word, its repeat word, and then
// ceil(count / lanes) results, during which input ready is low.
// The output register drains one result per cycle, so emission pace is set
// by the sink's ready. Lanes per repeat result are OUT_LANES clamped to 1..4,
// raised where needed so that no run exceeds 32 results.
module packbits_rle_decoder
    import pbrd_pkg::*;
#(
    parameter int OUT_LANES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pbrd_in_if.sink     i_in,
    pbrd_out_if.source  o_out
);

    t_cmd              cmd;
    t_status           status;
    logic              in_ready;
    t_byte             lane [LaneFields];
    logic [CountW-1:0] lane_count;
    logic              last_of_run;
    logic              out_valid;

    // Phase control
    pbrd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_last_in  (i_in.last_in),
        .i_status   (status),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    // Run count, repeat byte and output register
    pbrd_dp #(
        .OUT_LANES (OUT_LANES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_data_byte   (i_in.data_byte),
        .i_last_in     (i_in.last_in),
        .i_out_ready   (o_out.ready),
        .o_status      (status),
        .o_out_valid   (out_valid),
        .o_lane        (lane),
        .o_lane_count  (lane_count),
        .o_last_of_run (last_of_run)
    );

    // Drive the channels
    assign i_in.ready        = in_ready;
    assign o_out.valid       = out_valid;
    assign o_out.lane0_byte  = lane[0];
    assign o_out.lane1_byte  = lane[1];
    assign o_out.lane2_byte  = lane[2];
    assign o_out.lane3_byte  = lane[3];
    assign o_out.lane_count  = lane_count;
    assign o_out.last_of_run = last_of_run;

endmodule
